/* rtl/core/frd_pkg.sv */
// Shared types and constants of the frame rate repeat/drop block.
// Depends on nothing; every other file refers to it by scoped names.
package frd_pkg;

  localparam int MAX_REPEATS = 64;
  localparam int CNT_W       = (MAX_REPEATS > 1) ? $clog2(MAX_REPEATS) : 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IN_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_PERIOD = CFG_IDX_W'(1);

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic               end_of_stream;
    logic signed [63:0] presentation_time;
    logic signed [63:0] decode_time;
    logic        [31:0] frame_flags;
    logic        [31:0] frame_duration;
  } in_beat_t;

  typedef struct packed {
    logic               end_marker;
    logic               from_held;
    logic signed [63:0] out_presentation_time;
    logic signed [63:0] out_decode_time;
    logic        [31:0] out_flags;
    logic        [31:0] out_duration;
    logic               held_replaced;
    logic               last_of_run;
    logic               repeat_overflow;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_eos;
    logic load_pass;
    logic load_repeat;
    logic align;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_eos;
    logic held_valid;
    logic gap_neg;
    logic below_out;
    logic below_pass;
    logic rep_last;
    logic slot_free;
  } dp_status_t;

endpackage

/* rtl/core/frd_datapath.sv */
// Datapath of the frame rate repeat/drop block: period registers, held frame,
// gap and copy timestamps, result register. Depends on frd_pkg.
module frd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  frd_pkg::in_beat_t              frame_beat,
  input  logic                           result_stall,
  output logic                           result_valid,
  output frd_pkg::out_beat_t             result_beat,
  input  frd_pkg::dp_cmd_t               cmd,
  output frd_pkg::dp_status_t            status
);

  logic [31:0] in_period;
  logic [31:0] out_period;

  logic        held_valid;
  logic [63:0] held_pts;
  logic [63:0] held_dts;
  logic [31:0] held_dur;

  logic        cur_eos;
  logic [63:0] cur_pts;
  logic [63:0] cur_dts;
  logic [31:0] cur_flags;
  logic [31:0] cur_dur;

  logic [63:0] gap;
  logic        gap_neg;
  logic [63:0] cp_pts;
  logic [63:0] cp_dts;
  logic [frd_pkg::CNT_W-1:0] rep_cnt;

  logic [63:0] pts_key;
  logic [63:0] held_key;
  logic [64:0] gap_diff;
  logic [32:0] pass_limit;
  logic [32:0] twice_out;
  logic        rep_final;
  logic        rep_cap;
  logic        rep_last;
  logic [63:0] cp_pts_step;
  logic [63:0] cp_dts_step;
  logic        slot_free;

  // Flip the sign bit so an unsigned subtract orders signed times.
  assign pts_key     = frame_beat.presentation_time ^ frd_pkg::SIGN64;
  assign held_key    = held_pts ^ frd_pkg::SIGN64;
  assign gap_diff    = {1'b0, pts_key} - {1'b0, held_key};

  assign pass_limit  = {1'b0, out_period} + {1'b0, in_period};
  assign twice_out   = {out_period, 1'b0};
  // Gap after this copy drops below one period.
  assign rep_final   = gap < {31'b0, twice_out};
  assign rep_cap     = rep_cnt == frd_pkg::CNT_W'(frd_pkg::MAX_REPEATS - 1);
  assign rep_last    = rep_final || rep_cap;
  assign cp_pts_step = cp_pts + {32'b0, out_period};
  assign cp_dts_step = cp_dts + {32'b0, out_period};
  assign slot_free   = !result_valid || !result_stall;

  always_comb begin
    status.is_eos     = cur_eos;
    status.held_valid = held_valid;
    status.gap_neg    = gap_neg;
    status.below_out  = gap < {32'b0, out_period};
    status.below_pass = gap < {31'b0, pass_limit};
    status.rep_last   = rep_last;
    status.slot_free  = slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_period  <= 32'd1;
      out_period <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        frd_pkg::REG_IN_PERIOD:  in_period  <= cfg_data;
        frd_pkg::REG_OUT_PERIOD: out_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_pts   <= '0;
      held_dts   <= '0;
      held_dur   <= '0;
    end else if (cmd.load_pass) begin
      held_valid <= 1'b1;
      held_pts   <= cur_pts;
      held_dts   <= cur_dts;
      held_dur   <= out_period;
    end else if (cmd.align) begin
      held_pts <= cur_pts - gap;
      held_dts <= cur_dts - gap;
      held_dur <= cur_dur;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_eos   <= frame_beat.end_of_stream;
      cur_pts   <= frame_beat.presentation_time;
      cur_dts   <= frame_beat.decode_time;
      cur_flags <= frame_beat.frame_flags;
      cur_dur   <= frame_beat.frame_duration;
      gap       <= gap_diff[63:0];
      gap_neg   <= gap_diff[64];
      cp_pts    <= held_pts;
      cp_dts    <= held_dts;
      rep_cnt   <= '0;
    end else if (cmd.load_repeat) begin
      gap     <= gap - {32'b0, out_period};
      cp_pts  <= cp_pts_step;
      cp_dts  <= cp_dts_step;
      rep_cnt <= rep_cnt + frd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_eos || cmd.load_pass || cmd.load_repeat) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_eos) begin
      result_beat.end_marker            <= 1'b1;
      result_beat.from_held             <= 1'b0;
      result_beat.out_presentation_time <= '0;
      result_beat.out_decode_time       <= '0;
      result_beat.out_flags             <= '0;
      result_beat.out_duration          <= '0;
      result_beat.held_replaced         <= 1'b0;
      result_beat.last_of_run           <= 1'b1;
      result_beat.repeat_overflow       <= 1'b0;
    end else if (cmd.load_pass) begin
      result_beat.end_marker            <= 1'b0;
      result_beat.from_held             <= 1'b0;
      result_beat.out_presentation_time <= cur_pts;
      result_beat.out_decode_time       <= cur_dts;
      result_beat.out_flags             <= cur_flags;
      result_beat.out_duration          <= out_period;
      result_beat.held_replaced         <= 1'b1;
      result_beat.last_of_run           <= 1'b1;
      result_beat.repeat_overflow       <= 1'b0;
    end else if (cmd.load_repeat) begin
      result_beat.end_marker            <= 1'b0;
      result_beat.from_held             <= 1'b1;
      result_beat.out_presentation_time <= cp_pts_step;
      result_beat.out_decode_time       <= cp_dts_step;
      result_beat.out_flags             <= '0;
      result_beat.out_duration          <= held_dur;
      result_beat.held_replaced         <= rep_last;
      result_beat.last_of_run           <= rep_last;
      result_beat.repeat_overflow       <= rep_last && !rep_final;
    end
  end

endmodule

/* rtl/core/frd_ctrl.sv */
// Controller of the frame rate repeat/drop block: sequences accept, decide,
// repeat and align steps. Depends on frd_pkg.
module frd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  frd_pkg::dp_status_t status,
  output frd_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_REPEAT = 4'b0100,
    ST_ALIGN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign frame_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (frame_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_eos) begin
          if (status.slot_free) begin
            cmd.load_eos = 1'b1;
            state_next   = ST_IDLE;
          end
        end else if (status.held_valid && (status.gap_neg || status.below_out)) begin
          state_next = ST_IDLE;
        end else if (status.held_valid && status.below_pass) begin
          state_next = ST_REPEAT;
        end else if (status.slot_free) begin
          cmd.load_pass = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_REPEAT: begin
        if (status.slot_free) begin
          cmd.load_repeat = 1'b1;
          if (status.rep_last) begin
            state_next = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/frame_rate_repeat_drop.sv */
// Top level of the frame rate repeat/drop block: controller plus datapath.
// Depends on frd_pkg, frd_ctrl and frd_datapath.
//
//   channel   signals                               beat type
//   frame     frame_valid, frame_stall, frame_beat  frd_pkg::in_beat_t
//   result    result_valid, result_stall, result_beat frd_pkg::out_beat_t
//   config    cfg_write, cfg_index, cfg_data        32-bit period registers
//
// One frame at a time. A frame is taken in the idle state and decided in the next
// cycle; end of stream, pass-on and drop finish with the decision. A repeat run
// of n copies loads the copies one after another, then aligns the held frame.
// A beat that is due while a stalled beat still holds the result register waits.
// Reset (rst, synchronous) empties the held frame and sets both periods to 1.
// The result register lets the next frame be taken while a beat still waits.
module frame_rate_repeat_drop (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           frame_valid,
  output logic                           frame_stall,
  input  frd_pkg::in_beat_t              frame_beat,
  output logic                           result_valid,
  input  logic                           result_stall,
  output frd_pkg::out_beat_t             result_beat
);

  frd_pkg::dp_cmd_t    cmd;
  frd_pkg::dp_status_t status;

  // Sequence the work: take, decide, repeat, align.
  frd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Hold periods and the held frame; compute gaps and copy times.
  frd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_beat   (frame_beat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_beat  (result_beat),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

/* tb/sv/frame_rate_repeat_drop_chk.sv */
// Scoreboard for frame_rate_repeat_drop: watches the config port and both
// beat channels, retimes every accepted frame and compares each result beat.
// Depends on frd_pkg for the beat types, register indexes and MAX_REPEATS.
module frame_rate_repeat_drop_chk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           frame_valid,
  input  logic                           frame_stall,
  input  frd_pkg::in_beat_t              frame_beat,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  frd_pkg::out_beat_t             result_beat,
  output int                             errors,
  output int                             waiting,
  output int                             frames,
  output int                             beats,
  output int                             drops,
  output int                             runs,
  output int                             capped
);

  logic [31:0] in_period, out_period;

  // timing of the frame kept as reference
  logic        held_ok;
  logic [63:0] held_pts, held_dts;
  logic [31:0] held_flg, held_dur;

  frd_pkg::out_beat_t retimed_q[$];

  task automatic report(input string msg);
    if (errors < 20) $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic retime(input frd_pkg::in_beat_t f);
    frd_pkg::out_beat_t r;
    logic [63:0] a, b, gap, out64, cp_pts, cp_dts;
    int n;
    logic more;
    r = '0;
    out64 = {32'h0, out_period};
    // order-preserving unsigned view of the signed times gives the exact gap
    a = f.presentation_time ^ frd_pkg::SIGN64;
    b = held_pts ^ frd_pkg::SIGN64;
    gap = a - b;
    if (f.end_of_stream) begin
      r.end_marker = 1'b1;
      r.last_of_run = 1'b1;
      retimed_q.push_back(r);
    end else if (held_ok && (a < b || gap < out64)) begin
      drops++;
    end else if (held_ok && gap < out64 + {32'h0, in_period}) begin
      cp_pts = held_pts;
      cp_dts = held_dts;
      n = 0;
      more = 1'b1;
      while (more) begin
        cp_pts += out64;
        cp_dts += out64;
        gap -= out64;
        n++;
        more = (gap >= out64) && (n < frd_pkg::MAX_REPEATS);
        r = '0;
        r.from_held = 1'b1;
        r.out_presentation_time = cp_pts;
        r.out_decode_time = cp_dts;
        r.out_duration = held_dur;
        r.held_replaced = !more;
        r.last_of_run = !more;
        r.repeat_overflow = !more && (gap >= out64);
        retimed_q.push_back(r);
      end
      runs++;
      if (gap >= out64) capped++;
      // align the new reference back by what is left of the gap
      held_pts = f.presentation_time - gap;
      held_dts = f.decode_time - gap;
      held_flg = f.frame_flags;
      held_dur = f.frame_duration;
    end else begin
      held_ok = 1'b1;
      held_pts = f.presentation_time;
      held_dts = f.decode_time;
      held_flg = f.frame_flags;
      held_dur = out_period;
      r.out_presentation_time = f.presentation_time;
      r.out_decode_time = f.decode_time;
      r.out_flags = f.frame_flags;
      r.out_duration = out_period;
      r.held_replaced = 1'b1;
      r.last_of_run = 1'b1;
      retimed_q.push_back(r);
    end
  endtask

  task automatic check_beat(input frd_pkg::out_beat_t got);
    frd_pkg::out_beat_t want;
    if (retimed_q.size() == 0) begin
      report("result beat with no frame waiting for it");
    end else begin
      want = retimed_q.pop_front();
      if (got.end_marker !== want.end_marker)
        report($sformatf("end_marker %0d, want %0d", got.end_marker, want.end_marker));
      if (got.from_held !== want.from_held)
        report($sformatf("from_held %0d, want %0d", got.from_held, want.from_held));
      if (got.out_presentation_time !== want.out_presentation_time)
        report($sformatf("out_presentation_time %h, want %h",
                         got.out_presentation_time, want.out_presentation_time));
      if (got.out_decode_time !== want.out_decode_time)
        report($sformatf("out_decode_time %h, want %h",
                         got.out_decode_time, want.out_decode_time));
      if (got.out_flags !== want.out_flags)
        report($sformatf("out_flags %h, want %h", got.out_flags, want.out_flags));
      if (got.out_duration !== want.out_duration)
        report($sformatf("out_duration %h, want %h", got.out_duration, want.out_duration));
      if (got.held_replaced !== want.held_replaced)
        report($sformatf("held_replaced %0d, want %0d",
                         got.held_replaced, want.held_replaced));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0d, want %0d", got.last_of_run, want.last_of_run));
      if (got.repeat_overflow !== want.repeat_overflow)
        report($sformatf("repeat_overflow %0d, want %0d",
                         got.repeat_overflow, want.repeat_overflow));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_period = 32'd1;
      out_period = 32'd1;
      held_ok = 1'b0;
      held_pts = '0;
      held_dts = '0;
      held_flg = '0;
      held_dur = '0;
      retimed_q.delete();
      errors = 0;
      waiting = 0;
      frames = 0;
      beats = 0;
      drops = 0;
      runs = 0;
      capped = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          frd_pkg::REG_IN_PERIOD: in_period = cfg_data;
          frd_pkg::REG_OUT_PERIOD: out_period = cfg_data;
          default: ;
        endcase
      end
      if (frame_valid && !frame_stall) begin
        frames++;
        retime(frame_beat);
      end
      if (result_valid && !result_stall) begin
        beats++;
        check_beat(result_beat);
      end
      waiting = retimed_q.size();
    end
  end

endmodule

/* tb/sv/frame_rate_repeat_drop_tb.sv */
// Stimulus and verdict for frame_rate_repeat_drop: directed frames, then random
// frame streams under eight period settings. Depends on frd_pkg, the block
// and frame_rate_repeat_drop_chk, which does all prediction and comparison.
module frame_rate_repeat_drop_tb;

  localparam int ITEMS_PER_SET = 24;
  localparam int N_SETS        = 8;
  localparam int QUIET         = 8;    // covers an in-flight drop or the align cycle
  localparam int DRAIN         = 16;
  localparam int STALL_LIMIT   = 1000; // cycles without any accepted beat

  // period settings of the random part: input period, output period, and the
  // nominal spacing of the frame stream fed under that setting
  localparam logic [0:7][31:0] SET_IN = {
    32'd1000, 32'd400, 32'd1001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd64, 32'd0};
  localparam logic [0:7][31:0] SET_OUT = {
    32'd400, 32'd1000, 32'd1000, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd0, 32'd300};
  localparam logic [0:7][31:0] SET_STEP = {
    32'd1000, 32'd400, 32'd1001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd64, 32'd250};
  // setting that runs with no sender gaps and no receiver stalls
  localparam int FULL_RATE_SET = 2;

  localparam logic signed [63:0] TS_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_write = 1'b0;
  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [frd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic               frame_valid = 1'b0;
  logic               frame_stall;
  frd_pkg::in_beat_t  frame_beat  = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  frd_pkg::out_beat_t result_beat;

  logic idle_on = 1'b1; // enables sender gaps and receiver stalls
  int   quiet_count = 0;

  int errors, waiting, frames, beats, drops, runs, capped;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frame_rate_repeat_drop i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_beat   (frame_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  frame_rate_repeat_drop_chk i_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_beat   (frame_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .errors       (errors),
    .waiting      (waiting),
    .frames       (frames),
    .beats        (beats),
    .drops        (drops),
    .runs         (runs),
    .capped       (capped)
  );

  // Stall the result channel at random; the stall is free to rise with no beat
  // pending, so it also lands on the decide and align cycles.
  always @(negedge clk) begin
    result_stall <= idle_on && ($urandom_range(99) < 37);
  end

  // Count cycles in which neither channel moves a beat; give up at the limit.
  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (result_valid && !result_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count == STALL_LIMIT) begin
        $display("%0t no beat moved for %0d cycles, %0d results still due",
                 $time, STALL_LIMIT, waiting);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic frd_pkg::in_beat_t frame_item(input logic eos,
                                                   input logic signed [63:0] pts,
                                                   input logic signed [63:0] dts,
                                                   input logic [31:0] flg,
                                                   input logic [31:0] dur);
    frd_pkg::in_beat_t f;
    f.end_of_stream = eos;
    f.presentation_time = pts;
    f.decode_time = dts;
    f.frame_flags = flg;
    f.frame_duration = dur;
    return f;
  endfunction

  // Offer one frame beat, called and returning at a falling edge. Valid stays
  // high on return so that a following beat can go out back to back.
  task automatic send(input frd_pkg::in_beat_t f);
    while (idle_on && $urandom_range(99) < 37) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_beat <= f;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, let every due result drain and the block settle, then write
  // both period registers.
  task automatic set_periods(input logic [31:0] in_p, input logic [31:0] out_p);
    frame_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (QUIET) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= frd_pkg::REG_IN_PERIOD;
    cfg_data <= in_p;
    @(negedge clk);
    cfg_index <= frd_pkg::REG_OUT_PERIOD;
    cfg_data <= out_p;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    frd_pkg::in_beat_t  f;
    logic signed [63:0] t, rnd;
    logic signed [63:0] stream_pts; // nondecreasing timeline of well-formed frames
    logic [63:0]        step_len, jit;
    logic [31:0]        flg, dur;
    int                 roll;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, periods at their reset value of 1.
    // End of stream before any frame, with every timing bit set.
    send(frame_item(1'b1, -64'sd1, -64'sd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // First frame passes at the lowest time; held decode time at the top.
    send(frame_item(1'b0, TS_MIN, TS_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Same time again: drop.
    send(frame_item(1'b0, TS_MIN, 64'sd0, 32'h0, 32'h0));
    // One period on: one copy, its decode time wraps past the top.
    send(frame_item(1'b0, TS_MIN + 64'sd1, 64'sd0, 32'h0000_1234, 32'd7));
    // More than half the range ahead: a wrapped difference would look negative.
    t = 64'sd256;
    send(frame_item(1'b0, t, TS_MAX - 64'sd15, 32'hA5A5_5A5A, 32'd3));
    // Behind the held frame: drop.
    send(frame_item(1'b0, -64'sd5, TS_MIN, 32'h0, 32'h0));
    send(frame_item(1'b1, 64'sd0, 64'sd0, 32'h0, 32'h0));

    // Output period 1 with a huge input period: exactly 64 copies, then one past
    // the cap; both copy runs walk the decode time through the wrap.
    set_periods(32'hFFFF_FFFF, 32'd1);
    t = t + 64'sd64;
    send(frame_item(1'b0, t, TS_MAX - 64'sd40, 32'h0F0F_0F0F, 32'hFFFF_FFFF));
    t = t + 64'sd65;
    send(frame_item(1'b0, t, TS_MIN, 32'h0, 32'h0000_0001));
    t = t - 64'sd1;

    // Zero output period: any gap under the input period hits the cap in place.
    set_periods(32'd3, 32'd0);
    send(frame_item(1'b0, t + 64'sd2, t, 32'h1111_1111, 32'd9));
    t = t + 64'sd3;
    send(frame_item(1'b0, t, t, 32'h2222_2222, 32'd10));

    // Zero input period: the pass threshold falls to the output period.
    set_periods(32'd0, 32'd5);
    send(frame_item(1'b0, t + 64'sd4, t, 32'h0, 32'd0));
    t = t + 64'sd5;
    send(frame_item(1'b0, t, t, 32'h3333_3333, 32'd11));

    // Both periods at the top: the pass threshold needs 33 bits.
    set_periods(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(frame_item(1'b0, t + 64'sh0_FFFF_FFFE, t, 32'h0, 32'd0));
    t = t + 64'sh0_FFFF_FFFF;
    send(frame_item(1'b0, t, t, 32'h4444_4444, 32'd12));
    t = t + 64'sh1_FFFF_FFFD;
    send(frame_item(1'b0, t, t - 64'sd7, 32'h5555_5555, 32'd13));
    t = t - 64'sh0_FFFF_FFFE + 64'sh1_FFFF_FFFE;
    send(frame_item(1'b0, t, t, 32'h6666_6666, 32'd14));
    stream_pts = t;

    // Random part: mostly a steady stream at the setting's spacing with
    // jitter, mixed with end of stream, late frames, jumps and wild times.
    for (int s = 0; s < N_SETS; s++) begin
      set_periods(SET_IN[s], SET_OUT[s]);
      idle_on <= (s != FULL_RATE_SET);
      step_len = {32'h0, SET_STEP[s]};
      jit = step_len >> 3;
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        roll = $urandom_range(99);
        flg = $urandom;
        dur = $urandom;
        if (roll < 6) begin
          f = frame_item(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, flg, dur);
        end else if (roll < 12) begin
          // late frame, usually behind the held one
          t = stream_pts - 64'($urandom_range(1, 5000));
          f = frame_item(1'b0, t, t - 64'($urandom_range(0, 100)), flg, dur);
        end else if (roll < 17) begin
          stream_pts = stream_pts + {24'h0, 8'($urandom_range(0, 255)), 32'($urandom)};
          f = frame_item(1'b0, stream_pts, stream_pts, flg, dur);
        end else if (roll < 21) begin
          // wild time; advance the stream only if it lies ahead, so the
          // held frame never ends up in front of the stream
          rnd = {$urandom, $urandom};
          if (rnd > stream_pts) stream_pts = rnd;
          f = frame_item(1'b0, rnd, {$urandom, $urandom}, flg, dur);
        end else begin
          stream_pts = stream_pts + step_len + 64'($urandom_range(0, 32'(2 * jit))) - jit;
          f = frame_item(1'b0, stream_pts, stream_pts - 64'($urandom_range(0, 3000)),
                         flg, dur);
        end
        send(f);
      end
    end

    // Drain, wait for stray beats, then decide.
    frame_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("covered %0d frames: %0d dropped, %0d repeat runs (%0d cut at the cap)",
             frames, drops, runs, capped);
    $display("checked %0d result beats over %0d period settings, %0d mismatches",
             beats, N_SETS + 5, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
